/* hdl/vrt_pkg.sv */
// shared types and constants of the voxel ray traversal block
package vrt_pkg;

  localparam logic [1:0]  KIND_PROBE = 2'd0;
  localparam logic [1:0]  KIND_HIT   = 2'd1;
  localparam logic [1:0]  KIND_MISS  = 2'd2;

  localparam logic        CMD_START  = 1'b0;
  localparam logic        CMD_ANSWER = 1'b1;

  localparam logic [15:0] MAXD_RESET = 16'd2048;
  localparam logic [31:0] TSTEP_TINY = 32'd655360000;
  localparam logic [31:0] T_SAT      = 32'hFFFF_FFFF;
  localparam logic [12:0] ONE_Q12    = 13'd4096;
  localparam logic [4:0]  DIV_MSB    = 5'd30;
  localparam logic [1:0]  AXIS_LAST  = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic        [7:0]  block_type;
  } in_t;

  typedef struct packed {
    logic        [1:0]  kind;
    logic signed [19:0] voxel_x;
    logic signed [19:0] voxel_y;
    logic signed [19:0] voxel_z;
    logic signed [15:0] chunk_x;
    logic signed [15:0] chunk_z;
    logic        [3:0]  local_x;
    logic        [3:0]  local_z;
    logic        [2:0]  face;
    logic        [31:0] distance;
    logic        [7:0]  hit_type;
  } out_t;

  typedef struct packed {
    logic       start_load;
    logic       hit_load;
    logic       div_init;
    logic       div_step;
    logic       div_one;
    logic       mul1;
    logic       mul2;
    logic       adv;
    logic       chk1;
    logic       chk2;
    logic       out_load;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic pending;
    logic blk_nz;
  } sts_t;

endpackage

/* hdl/voxel_ray_traversal.sv */
// top level of the voxel ray traversal block
//
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_ready_o    in_i (in_t)
// out       output     out_valid_o / out_ready_i  out_o (out_t)
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_data_i (max_distance)
//
// a start transaction loads the ray, then runs per axis an init state,
// a 31-step serial divide and the multiply states mul1 and mul2,
// then the dda step, two chunk split stages and the output load
// an answer with a walk pending runs the dda step (none for a hit), the chunk split
// stages and output load, else no result; the lookup round trip paces the walk
// reset clears the ray state and sets max_distance to 2048; no clearing pass
// input is taken only between transactions; a stalled output holds the next result
module voxel_ray_traversal import vrt_pkg::*; #(
  parameter int unsigned CHUNK_WIDTH = 16,
  parameter int unsigned CHUNK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  vrt_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_i.cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vrt_datapath #(
    .CHUNK_WIDTH (CHUNK_WIDTH),
    .CHUNK_DEPTH (CHUNK_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_o      (out_o)
  );

endmodule

/* hdl/vrt_datapath.sv */
// datapath: ray state, shared divider, multipliers, dda step and chunk split
module vrt_datapath import vrt_pkg::*; #(
  parameter int unsigned CHUNK_WIDTH = 16,
  parameter int unsigned CHUNK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  in_t         in_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output out_t        out_o
);

  localparam int unsigned LW = $clog2(CHUNK_WIDTH);
  localparam int unsigned SW = 21 + LW;
  localparam int unsigned PX = SW + 21;
  localparam longint unsigned MW = (64'd1 << SW) / CHUNK_WIDTH;
  localparam longint unsigned KW = ((64'd1 << 19) + CHUNK_WIDTH - 1) / CHUNK_WIDTH;
  localparam logic [20:0] OFFW = 21'(KW * CHUNK_WIDTH);
  localparam int unsigned LD = $clog2(CHUNK_DEPTH);
  localparam int unsigned SD = 21 + LD;
  localparam int unsigned PZ = SD + 21;
  localparam longint unsigned MD = (64'd1 << SD) / CHUNK_DEPTH;
  localparam longint unsigned KD = ((64'd1 << 19) + CHUNK_DEPTH - 1) / CHUNK_DEPTH;
  localparam logic [20:0] OFFD = 21'(KD * CHUNK_DEPTH);

  logic [19:0] vox_q   [3];
  logic [31:0] tnext_q [3];
  logic [31:0] tstep_q [3];
  logic        neg_q   [3];
  logic [15:0] mag_q   [3];
  logic [11:0] frac_q  [3];
  logic        dzero_q [3];
  logic [9:0]  cnt_q, lim_q;
  logic [31:0] edist_q;
  logic [2:0]  eface_q;
  logic        pend_q;
  logic [15:0] maxd_q;
  logic [1:0]  kind_q;
  logic [7:0]  htype_q;
  logic [15:0] rem_q;
  logic [29:0] quo_q;
  logic [42:0] prod_q;
  logic [20:0] ux_q, uz_q;
  logic [PX-1:0] px_q;
  logic [PZ-1:0] pz_q;
  logic [15:0] cx_q, cz_q;
  logic [3:0]  lx_q, lz_q;
  out_t        out_q;

  logic [31:0] org [3];
  logic [15:0] dir [3];
  assign org[0] = in_i.origin_x;
  assign org[1] = in_i.origin_y;
  assign org[2] = in_i.origin_z;
  assign dir[0] = in_i.dir_x;
  assign dir[1] = in_i.dir_y;
  assign dir[2] = in_i.dir_z;

  // divider step
  logic [16:0] rem_sh;
  logic        div_ge;
  assign rem_sh = {rem_q, cmd_i.div_one};
  assign div_ge = rem_sh >= {1'b0, mag_q[cmd_i.axis]};

  // reciprocal and first boundary product
  logic [31:0] ts_val;
  logic [12:0] dist_val;
  assign ts_val   = (mag_q[cmd_i.axis] >= 16'd2) ? {2'b00, quo_q} : TSTEP_TINY;
  assign dist_val = neg_q[cmd_i.axis] ? {1'b0, frac_q[cmd_i.axis]}
                                      : 13'(ONE_Q12 - {1'b0, frac_q[cmd_i.axis]});

  // dda axis choice with strict compares: a tie goes to the later axis (z, then y)
  logic [1:0]  sel;
  logic [32:0] tsum;
  logic [31:0] tsat;
  logic [23:0] reach;
  always_comb begin
    if (tnext_q[0] < tnext_q[1] && tnext_q[0] < tnext_q[2]) begin
      sel = 2'd0;
    end else if (tnext_q[1] < tnext_q[2]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
  end
  assign tsum  = {1'b0, tnext_q[sel]} + {1'b0, tstep_q[sel]};
  assign tsat  = tsum[32] ? T_SAT : tsum[31:0];
  assign reach = {maxd_q, 8'd0};

  // chunk split by reciprocal multiply and one correction
  logic [20:0] ux_d, uz_d;
  logic [20:0] qx0, qz0, rx0, rz0, qx, qz, rx, rz;
  assign ux_d = {vox_q[0][19], vox_q[0]} + OFFW;
  assign uz_d = {vox_q[2][19], vox_q[2]} + OFFD;
  assign qx0  = px_q[SW +: 21];
  assign qz0  = pz_q[SD +: 21];
  assign rx0  = ux_q - 21'(qx0 * 21'(CHUNK_WIDTH));
  assign rz0  = uz_q - 21'(qz0 * 21'(CHUNK_DEPTH));
  always_comb begin
    if (rx0 >= 21'(CHUNK_WIDTH)) begin
      qx = qx0 + 21'd1;
      rx = rx0 - 21'(CHUNK_WIDTH);
    end else begin
      qx = qx0;
      rx = rx0;
    end
    if (rz0 >= 21'(CHUNK_DEPTH)) begin
      qz = qz0 + 21'd1;
      rz = rz0 - 21'(CHUNK_DEPTH);
    end else begin
      qz = qz0;
      rz = rz0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        vox_q[i]   <= '0;
        tnext_q[i] <= '0;
        tstep_q[i] <= '0;
        neg_q[i]   <= 1'b0;
      end
      cnt_q   <= '0;
      lim_q   <= '0;
      edist_q <= '0;
      eface_q <= '0;
      pend_q  <= 1'b0;
      maxd_q  <= MAXD_RESET;
    end else begin
      if (cfg_we_i) begin
        maxd_q <= cfg_data_i;
      end
      if (cmd_i.start_load) begin
        for (int i = 0; i < 3; i++) begin
          vox_q[i] <= org[i][31:12];
          neg_q[i] <= !($signed(dir[i]) > 16'sd0);
        end
        cnt_q   <= '0;
        lim_q   <= 10'(({2'b00, maxd_q} + {1'b0, maxd_q, 1'b0}) >> 8);
        edist_q <= '0;
        eface_q <= '0;
        pend_q  <= 1'b0;
      end
      if (cmd_i.hit_load) begin
        pend_q <= 1'b0;
      end
      if (cmd_i.mul1) begin
        tstep_q[cmd_i.axis] <= ts_val;
      end
      if (cmd_i.mul2) begin
        tnext_q[cmd_i.axis] <= dzero_q[cmd_i.axis] ? T_SAT : {1'b0, prod_q[42:12]};
      end
      if (cmd_i.adv) begin
        if (cnt_q >= lim_q) begin
          pend_q <= 1'b0;
        end else begin
          vox_q[sel]   <= neg_q[sel] ? vox_q[sel] - 20'd1 : vox_q[sel] + 20'd1;
          edist_q      <= tnext_q[sel];
          tnext_q[sel] <= tsat;
          eface_q      <= {sel, !neg_q[sel]};
          cnt_q        <= cnt_q + 10'd1;
          pend_q       <= !(tnext_q[sel] > {8'd0, reach});
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_load) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i]   <= dir[i][15] ? 16'(-dir[i]) : dir[i];
        frac_q[i]  <= org[i][11:0];
        dzero_q[i] <= dir[i] == 16'd0;
      end
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? 16'(rem_sh - {1'b0, mag_q[cmd_i.axis]}) : rem_sh[15:0];
      quo_q <= {quo_q[28:0], div_ge};
    end
    if (cmd_i.mul1) begin
      prod_q <= 43'(dist_val) * 43'(ts_val[29:0]);
    end
    if (cmd_i.hit_load) begin
      kind_q  <= KIND_HIT;
      htype_q <= in_i.block_type;
    end
    if (cmd_i.adv) begin
      htype_q <= '0;
      if (cnt_q >= lim_q || tnext_q[sel] > {8'd0, reach}) begin
        kind_q <= KIND_MISS;
      end else begin
        kind_q <= KIND_PROBE;
      end
    end
    if (cmd_i.chk1) begin
      ux_q <= ux_d;
      uz_q <= uz_d;
      px_q <= PX'(ux_d) * PX'(22'(MW));
      pz_q <= PZ'(uz_d) * PZ'(22'(MD));
    end
    if (cmd_i.chk2) begin
      cx_q <= 16'(qx - 21'(KW));
      cz_q <= 16'(qz - 21'(KD));
      lx_q <= rx[3:0];
      lz_q <= rz[3:0];
    end
    if (cmd_i.out_load) begin
      if (kind_q == KIND_MISS) begin
        out_q <= {KIND_MISS, ($bits(out_t) - 2)'(0)};
      end else begin
        out_q.kind     <= kind_q;
        out_q.voxel_x  <= vox_q[0];
        out_q.voxel_y  <= vox_q[1];
        out_q.voxel_z  <= vox_q[2];
        out_q.chunk_x  <= cx_q;
        out_q.chunk_z  <= cz_q;
        out_q.local_x  <= lx_q;
        out_q.local_z  <= lz_q;
        out_q.face     <= eface_q;
        out_q.distance <= edist_q;
        out_q.hit_type <= htype_q;
      end
    end
  end

  assign sts_o.pending = pend_q;
  assign sts_o.blk_nz  = in_i.block_type != 8'd0;
  assign out_o         = out_q;

endmodule

/* hdl/vrt_controller.sv */
// controller: sequences ray setup, dda steps and result handoff
module vrt_controller import vrt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_cmd_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DINIT = 4'd1;
  localparam logic [3:0] S_DSTEP = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_ADV   = 4'd5;
  localparam logic [3:0] S_CHK1  = 4'd6;
  localparam logic [3:0] S_CHK2  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_q, state_d;
  logic [4:0] bit_q, bit_d;
  logic [1:0] axis_q, axis_d;
  logic       oval_q, oval_d;
  logic       acc;

  assign in_ready_o  = state_q == S_IDLE;
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = oval_q;

  always_comb begin
    state_d = state_q;
    bit_d   = bit_q;
    axis_d  = axis_q;
    oval_d  = oval_q && !out_ready_i;
    cmd_o   = '0;
    cmd_o.axis    = axis_q;
    cmd_o.div_one = bit_q == DIV_MSB;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (in_cmd_i == CMD_START) begin
            cmd_o.start_load = 1'b1;
            axis_d  = '0;
            state_d = S_DINIT;
          end else if (sts_i.pending && sts_i.blk_nz) begin
            cmd_o.hit_load = 1'b1;
            state_d = S_CHK1;
          end else if (sts_i.pending) begin
            state_d = S_ADV;
          end
        end
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        bit_d   = DIV_MSB;
        state_d = S_DSTEP;
      end
      S_DSTEP: begin
        cmd_o.div_step = 1'b1;
        bit_d = bit_q - 5'd1;
        if (bit_q == '0) begin
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        if (axis_q == AXIS_LAST) begin
          state_d = S_ADV;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = S_DINIT;
        end
      end
      S_ADV: begin
        cmd_o.adv = 1'b1;
        state_d = S_CHK1;
      end
      S_CHK1: begin
        cmd_o.chk1 = 1'b1;
        state_d = S_CHK2;
      end
      S_CHK2: begin
        cmd_o.chk2 = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!oval_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          oval_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bit_q   <= '0;
      axis_q  <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      axis_q  <= axis_d;
      oval_q  <= oval_d;
    end
  end

endmodule

/* hdl/vrt_checker.sv */
// port checker for the voxel ray traversal block and its bind
module vrt_checker import vrt_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("output transaction dropped or changed while stalled");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.kind == KIND_PROBE || out_o.kind == KIND_HIT ||
                    out_o.kind == KIND_MISS)
    else $error("illegal result kind");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.kind == KIND_MISS |->
      out_o.voxel_x == '0 && out_o.distance == '0 && out_o.hit_type == '0 &&
      out_o.face == '0)
    else $error("miss carries nonzero fields");

  a_probe_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.kind == KIND_PROBE |-> out_o.hit_type == '0)
    else $error("probe carries a block type");

  a_hit_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.kind == KIND_HIT |-> out_o.hit_type != '0)
    else $error("hit without block type");

endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);
